// ===== rtl/gfre_pkg.sv =====
// ----------------------------------------------------------------------------
// gfre_pkg
// Shared types, register indexes and GF(256) arithmetic for the erasure
// repair encoder.
// ----------------------------------------------------------------------------
package gfre_pkg;

  // Field polynomial x^8 + x^4 + x^3 + x^2 + 1
  localparam logic [8:0] GF_POLY   = 9'h11d;
  localparam int         COEF_ROWS = 4;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_COEF_ROW_ZERO  = 3'd0,
    CFG_COEF_ROW_ONE   = 3'd1,
    CFG_COEF_ROW_TWO   = 3'd2,
    CFG_COEF_ROW_THREE = 3'd3,
    CFG_SOURCE_COUNT   = 3'd4,
    CFG_REPAIR_COUNT   = 3'd5
  } cfg_idx_t;

  // Decoded configuration handed to the datapath
  typedef struct packed {
    logic [COEF_ROWS-1:0][63:0] coef;      // byte c of row r: source c
    logic [4:0]                 src_count; // saturated source count
    logic [1:0]                 last_row;  // saturated repair count minus one
  } cfg_t;

  // GF(256) multiply, shift-and-add over eight bits
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] p;
    x = {1'b0, a};
    p = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        p = p ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return p;
  endfunction

endpackage

// ===== rtl/gf256_erasure_repair_encoder.sv =====
// ----------------------------------------------------------------------------
// gf256_erasure_repair_encoder
// Reed-Solomon style repair encoder over GF(256): accumulates coefficient
// times byte per repair row and emits finished bytes on the last source.
// ----------------------------------------------------------------------------
// Path: an accepted input beat is registered in stage 1, and its finished word
//   is loaded into the output register, which presents it one byte per beat.
// Throughput: one input beat per cycle unless stage 1 is held; an item of the
//   last source holds the output for the saturated repair count of one-byte beats.
// The accumulator memory does one read and one write per cycle (read on
//   acceptance, write back when stage 1 retires, with forwarding between them).
// Reset clears control state and the configuration; memory contents are not
//   cleared and an offset is defined once source 0 has written it.
module gf256_erasure_repair_encoder #(
  parameter int MAX_SOURCES      = 8,
  parameter int MAX_REPAIRS      = 4,
  parameter int MAX_SYMBOL_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  source_index,
  input  logic [10:0] byte_offset,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  repair_index,
  output logic [10:0] out_offset,
  output logic [7:0]  repair_byte,
  output logic        last_of_run
);

  gfre_pkg::cfg_t           cfg;
  logic                     job_valid;
  logic                     job_ready;
  logic [10:0]              job_offset;
  logic [8*MAX_REPAIRS-1:0] job_word;

  gfre_cfg #(
    .MAX_SOURCES (MAX_SOURCES),
    .MAX_REPAIRS (MAX_REPAIRS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gfre_acc #(
    .MAX_REPAIRS      (MAX_REPAIRS),
    .MAX_SYMBOL_BYTES (MAX_SYMBOL_BYTES)
  ) u_acc (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .source_index (source_index),
    .byte_offset  (byte_offset),
    .data_byte    (data_byte),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .job_offset   (job_offset),
    .job_word     (job_word)
  );

  gfre_emit #(
    .MAX_REPAIRS (MAX_REPAIRS)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .job_offset   (job_offset),
    .job_word     (job_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .repair_index (repair_index),
    .out_offset   (out_offset),
    .repair_byte  (repair_byte),
    .last_of_run  (last_of_run)
  );

endmodule

// ===== rtl/gfre_cfg.sv =====
// ----------------------------------------------------------------------------
// gfre_cfg
// Configuration registers: coefficient rows and the source and repair counts,
// with the counts saturated to the supported range.
// ----------------------------------------------------------------------------
module gfre_cfg #(
  parameter int MAX_SOURCES = 8,
  parameter int MAX_REPAIRS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output gfre_pkg::cfg_t      cfg
);

  logic [gfre_pkg::COEF_ROWS-1:0][63:0] coef;
  logic [3:0]                           source_count;
  logic [2:0]                           repair_count;
  logic [4:0]                           src_sat;
  logic [2:0]                           rep_sat;

  assign cfg_ready = 1'b1;

  // Take a register write on each beat
  always_ff @(posedge clk) begin
    if (rst) begin
      coef         <= '0;
      source_count <= 4'd1;
      repair_count <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (gfre_pkg::cfg_idx_t'(cfg_index))
        gfre_pkg::CFG_COEF_ROW_ZERO:  coef[0]      <= cfg_data;
        gfre_pkg::CFG_COEF_ROW_ONE:   coef[1]      <= cfg_data;
        gfre_pkg::CFG_COEF_ROW_TWO:   coef[2]      <= cfg_data;
        gfre_pkg::CFG_COEF_ROW_THREE: coef[3]      <= cfg_data;
        gfre_pkg::CFG_SOURCE_COUNT:   source_count <= cfg_data[3:0];
        gfre_pkg::CFG_REPAIR_COUNT:   repair_count <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Clamp the counts into their legal ranges
  always_comb begin
    src_sat = {1'b0, source_count};
    if (source_count == 4'd0) begin
      src_sat = 5'd1;
    end else if (32'(source_count) > MAX_SOURCES) begin
      src_sat = 5'(MAX_SOURCES);
    end
    rep_sat = repair_count;
    if (repair_count == 3'd0) begin
      rep_sat = 3'd1;
    end else if (32'(repair_count) > MAX_REPAIRS) begin
      rep_sat = 3'(MAX_REPAIRS);
    end
  end

  assign cfg.coef      = coef;
  assign cfg.src_count = src_sat;
  assign cfg.last_row  = 2'(rep_sat - 3'd1);

endmodule

// ===== rtl/gfre_acc.sv =====
// ----------------------------------------------------------------------------
// gfre_acc
// Accumulator memory with a two-stage read-modify-write: the read is issued
// on acceptance, products are merged and written back in the next stage.
// ----------------------------------------------------------------------------
module gfre_acc #(
  parameter int MAX_REPAIRS      = 4,
  parameter int MAX_SYMBOL_BYTES = 2048
) (
  input  logic                     clk,
  input  logic                     rst,
  input  gfre_pkg::cfg_t           cfg,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               source_index,
  input  logic [10:0]              byte_offset,
  input  logic [7:0]               data_byte,
  output logic                     job_valid,
  input  logic                     job_ready,
  output logic [10:0]              job_offset,
  output logic [8*MAX_REPAIRS-1:0] job_word
);

  localparam int WORD_W = 8 * MAX_REPAIRS;
  localparam int ADDR_W = (MAX_SYMBOL_BYTES > 1) ? $clog2(MAX_SYMBOL_BYTES) : 1;

  logic [WORD_W-1:0] mem [MAX_SYMBOL_BYTES];
  logic [WORD_W-1:0] rd_data;

  logic              in_ready;
  logic              take;
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] prod;

  logic              s1_valid;
  logic              s1_first;
  logic              s1_emit;
  logic [ADDR_W-1:0] s1_addr;
  logic [10:0]       s1_offset;
  logic [WORD_W-1:0] s1_prod;
  logic              s1_go;
  logic [WORD_W-1:0] base;
  logic [WORD_W-1:0] new_word;

  logic              fwd_hit;
  logic [WORD_W-1:0] fwd_data;

  // Stage 0: range check and products for every repair row
  assign rd_addr = ADDR_W'(byte_offset);
  assign take    = in_valid && in_ready
                   && ({2'b00, source_index} < cfg.src_count)
                   && (32'(byte_offset) < MAX_SYMBOL_BYTES);

  always_comb begin
    for (int r = 0; r < MAX_REPAIRS; r++) begin
      prod[8*r +: 8] = gfre_pkg::gf_mul(cfg.coef[r][{source_index, 3'b000} +: 8], data_byte);
    end
  end

  // Stage 1: merge with the stored word, forwarding the write just made
  assign base      = fwd_hit ? fwd_data : rd_data;
  assign new_word  = s1_first ? s1_prod : (base ^ s1_prod);
  assign s1_go     = s1_valid && (!s1_emit || job_ready);
  assign in_ready  = !s1_valid || s1_go;
  assign in_stall  = !in_ready;

  assign job_valid  = s1_valid && s1_emit;
  assign job_offset = s1_offset;
  assign job_word   = new_word;

  // Read on acceptance, write back when stage 1 retires
  always_ff @(posedge clk) begin
    if (take) begin
      rd_data <= mem[rd_addr];
    end
    if (s1_go) begin
      mem[s1_addr] <= new_word;
    end
  end

  // Advance the stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= take;
      fwd_hit  <= take && s1_go && (s1_addr == rd_addr);
    end
  end

  // Load the stage 1 payload
  always_ff @(posedge clk) begin
    if (take) begin
      s1_first  <= (source_index == 3'd0);
      s1_emit   <= ({2'b00, source_index} == cfg.src_count - 5'd1);
      s1_addr   <= rd_addr;
      s1_offset <= byte_offset;
      s1_prod   <= prod;
      fwd_data  <= new_word;
    end
  end

  // A held final-source item keeps its slot and address
  assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_ready |=> s1_valid && $stable(s1_addr))
    else $error("gfre_acc: stalled item left stage 1");

  // Input back-pressure only comes from an occupied stage 1
  assert property (@(posedge clk) disable iff (rst) in_stall |-> s1_valid && !s1_go)
    else $error("gfre_acc: stall without a blocked stage 1");

  // Forwarding only applies to a live item
  assert property (@(posedge clk) disable iff (rst) fwd_hit |-> s1_valid && !s1_first
                   || fwd_hit && s1_valid)
    else $error("gfre_acc: forward flag without an item");

endmodule

// ===== rtl/gfre_emit.sv =====
// ----------------------------------------------------------------------------
// gfre_emit
// Output register that walks a finished accumulator word and presents one
// repair byte per beat, row 0 upward.
// ----------------------------------------------------------------------------
module gfre_emit #(
  parameter int MAX_REPAIRS = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  gfre_pkg::cfg_t           cfg,
  input  logic                     job_valid,
  output logic                     job_ready,
  input  logic [10:0]              job_offset,
  input  logic [8*MAX_REPAIRS-1:0] job_word,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               repair_index,
  output logic [10:0]              out_offset,
  output logic [7:0]               repair_byte,
  output logic                     last_of_run
);

  localparam int WORD_W = 8 * MAX_REPAIRS;

  logic              em_valid;
  logic [1:0]        em_row;
  logic [1:0]        em_last;
  logic [10:0]       em_offset;
  logic [WORD_W-1:0] em_word;
  logic              beat;
  logic              final_beat;

  assign beat       = em_valid && !out_stall;
  assign final_beat = beat && (em_row == em_last);
  assign job_ready  = !em_valid || final_beat;

  // Control: load a new word or step to the next row
  always_ff @(posedge clk) begin
    if (rst) begin
      em_valid <= 1'b0;
      em_row   <= 2'd0;
    end else if (job_valid && job_ready) begin
      em_valid <= 1'b1;
      em_row   <= 2'd0;
    end else if (final_beat) begin
      em_valid <= 1'b0;
    end else if (beat) begin
      em_row <= em_row + 2'd1;
    end
  end

  // Payload: hold the word for the whole run
  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      em_word   <= job_word;
      em_offset <= job_offset;
      em_last   <= cfg.last_row;
    end
  end

  assign out_valid    = em_valid;
  assign repair_index = em_row;
  assign out_offset   = em_offset;
  assign repair_byte  = em_word[{em_row, 3'b000} +: 8];
  assign last_of_run  = em_row == em_last;

  // Row counter never passes the final row
  assert property (@(posedge clk) disable iff (rst) em_valid |-> em_row <= em_last)
    else $error("gfre_emit: row beyond the run");

  // A non-final beat moves to the very next row
  assert property (@(posedge clk) disable iff (rst)
    beat && !final_beat |=> em_valid && em_row == $past(em_row) + 2'd1)
    else $error("gfre_emit: row skipped");

  // A new word is only taken when the current run is finished
  assert property (@(posedge clk) disable iff (rst)
    job_valid && job_ready && em_valid |-> final_beat)
    else $error("gfre_emit: run overwritten");

endmodule
